// File: hdl/tdp_pkg.sv
// Shared types for the trial division prime test: microcode word layout,
// datapath control/status structs and the microcode ROM.
// No dependencies.
package tdp_pkg;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_NEXT,
    OP_SET_NOT,
    OP_SET_PRIME,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_NO_INPUT,
    HOLD_OUT_FULL
  } hold_e;

  typedef enum logic [2:0] {
    JMP_NEVER,
    JMP_ALWAYS,
    JMP_LT2,
    JMP_SQ_GT,
    JMP_DIV_BUSY,
    JMP_REM_NZ
  } jmp_e;

  localparam int STEP_BITS = 4;
  typedef logic [STEP_BITS-1:0] step_t;

  localparam step_t STEP_IDLE      = step_t'(0);
  localparam step_t STEP_RANGE     = step_t'(1);
  localparam step_t STEP_CHECK     = step_t'(2);
  localparam step_t STEP_DIV_INIT  = step_t'(3);
  localparam step_t STEP_DIV       = step_t'(4);
  localparam step_t STEP_NEXT      = step_t'(5);
  localparam step_t STEP_NOT_PRIME = step_t'(6);
  localparam step_t STEP_PRIME     = step_t'(7);
  localparam step_t STEP_EMIT      = step_t'(8);

  typedef struct packed {
    op_e   op;
    hold_e hold;
    jmp_e  jmp;
    step_t target;
  } uword_t;

  typedef struct packed {
    op_e  op;
    logic fire;
  } dp_ctl_t;

  typedef struct packed {
    logic in_valid;
    logic out_full;
    logic lt2;
    logic sq_gt;
    logic div_busy;
    logic rem_nz;
  } dp_stat_t;

  // Microcode program: one word per step
  function automatic uword_t ucode_rom(step_t step);
    uword_t w;
    case (step)
      STEP_IDLE:      w = '{op: OP_LOAD,      hold: HOLD_NO_INPUT, jmp: JMP_NEVER,
                            target: STEP_IDLE};
      STEP_RANGE:     w = '{op: OP_NONE,      hold: HOLD_NONE,     jmp: JMP_LT2,
                            target: STEP_NOT_PRIME};
      STEP_CHECK:     w = '{op: OP_NONE,      hold: HOLD_NONE,     jmp: JMP_SQ_GT,
                            target: STEP_PRIME};
      STEP_DIV_INIT:  w = '{op: OP_DIV_INIT,  hold: HOLD_NONE,     jmp: JMP_NEVER,
                            target: STEP_IDLE};
      STEP_DIV:       w = '{op: OP_DIV_STEP,  hold: HOLD_NONE,     jmp: JMP_DIV_BUSY,
                            target: STEP_DIV};
      STEP_NEXT:      w = '{op: OP_NEXT,      hold: HOLD_NONE,     jmp: JMP_REM_NZ,
                            target: STEP_CHECK};
      STEP_NOT_PRIME: w = '{op: OP_SET_NOT,   hold: HOLD_NONE,     jmp: JMP_ALWAYS,
                            target: STEP_EMIT};
      STEP_PRIME:     w = '{op: OP_SET_PRIME, hold: HOLD_NONE,     jmp: JMP_NEVER,
                            target: STEP_IDLE};
      STEP_EMIT:      w = '{op: OP_EMIT,      hold: HOLD_OUT_FULL, jmp: JMP_ALWAYS,
                            target: STEP_IDLE};
      default:        w = '{op: OP_NONE,      hold: HOLD_NONE,     jmp: JMP_ALWAYS,
                            target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: hdl/tdp_seq.sv
// Microcode sequencer: step counter, ROM lookup, hold and jump logic.
// Depends on tdp_pkg.
module tdp_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tdp_pkg::dp_stat_t  stat_i,
  output tdp_pkg::dp_ctl_t   ctl_o
);
  import tdp_pkg::*;

  step_t  step_q, step_d;
  uword_t uw;
  logic   hold;
  logic   take;

  assign uw = ucode_rom(step_q);

  assign hold = ((uw.hold == HOLD_NO_INPUT) && !stat_i.in_valid) ||
                ((uw.hold == HOLD_OUT_FULL) && stat_i.out_full);

  always_comb begin
    case (uw.jmp)
      JMP_NEVER:    take = 1'b0;
      JMP_ALWAYS:   take = 1'b1;
      JMP_LT2:      take = stat_i.lt2;
      JMP_SQ_GT:    take = stat_i.sq_gt;
      JMP_DIV_BUSY: take = stat_i.div_busy;
      JMP_REM_NZ:   take = stat_i.rem_nz;
      default:      take = 1'b1;
    endcase
  end

  always_comb begin
    if (hold) begin
      step_d = step_q;
    end else if (take) begin
      step_d = uw.target;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctl_o.op   = uw.op;
  assign ctl_o.fire = !hold;

endmodule

// File: hdl/tdp_datapath.sv
// Datapath: operand registers, bit-serial remainder unit, running square of
// the trial divisor and the output register. Depends on tdp_pkg.
module tdp_datapath #(
  parameter int VALUE_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tdp_pkg::dp_ctl_t       ctl_i,
  output tdp_pkg::dp_stat_t      stat_o,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [VALUE_BITS-1:0]  value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   is_prime_o
);
  import tdp_pkg::*;

  localparam int CNT_BITS = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [VALUE_BITS-1:0] shf_q, shf_d;
  logic [VALUE_BITS-1:0] rem_q, rem_d;
  logic [VALUE_BITS-1:0] div_q, div_d;
  logic [VALUE_BITS:0]   sq_q, sq_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic                  res_q, res_d;
  logic                  out_valid_q;
  logic                  is_prime_q;

  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   diff;
  logic                  ge;
  logic                  run;

  assign run = ctl_i.fire;

  // One restoring-division step: bring in the next dividend bit
  assign trial = {rem_q, shf_q[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = trial >= {1'b0, div_q};

  always_comb begin
    val_d = val_q;
    shf_d = shf_q;
    rem_d = rem_q;
    div_d = div_q;
    sq_d  = sq_q;
    cnt_d = cnt_q;
    res_d = res_q;
    if (run) begin
      case (ctl_i.op)
        OP_LOAD: begin
          val_d = value_i;
          div_d = VALUE_BITS'(2);
          sq_d  = (VALUE_BITS + 1)'(4);
        end
        OP_DIV_INIT: begin
          shf_d = val_q;
          rem_d = '0;
          cnt_d = CNT_BITS'(VALUE_BITS - 1);
        end
        OP_DIV_STEP: begin
          shf_d = {shf_q[VALUE_BITS-2:0], 1'b0};
          rem_d = ge ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
          cnt_d = cnt_q - 1'b1;
        end
        OP_NEXT: begin
          // (d+1)^2 = d^2 + 2d + 1
          div_d = div_q + 1'b1;
          sq_d  = sq_q + {div_q, 1'b1};
        end
        OP_SET_NOT:   res_d = 1'b0;
        OP_SET_PRIME: res_d = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    shf_q <= shf_d;
    rem_q <= rem_d;
    div_q <= div_d;
    sq_q  <= sq_d;
    cnt_q <= cnt_d;
    res_q <= res_d;
    if (run && (ctl_i.op == OP_EMIT)) begin
      is_prime_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (run && (ctl_i.op == OP_EMIT)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign in_ready_o  = (ctl_i.op == OP_LOAD);
  assign out_valid_o = out_valid_q;
  assign is_prime_o  = is_prime_q;

  assign stat_o.in_valid = in_valid_i;
  assign stat_o.out_full = out_valid_q && !out_ready_i;
  assign stat_o.lt2      = val_q < VALUE_BITS'(2);
  assign stat_o.sq_gt    = sq_q > {1'b0, val_q};
  assign stat_o.div_busy = cnt_q != '0;
  assign stat_o.rem_nz   = rem_q != '0;

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.op == OP_DIV_STEP) |-> (rem_q < div_q))
    else $error("partial remainder not below divisor");

  a_div_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.op == OP_DIV_INIT) |-> ((div_q >= VALUE_BITS'(2)) && (sq_q <= {1'b0, val_q})))
    else $error("trial divisor out of range");

  a_prime_ge2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run && (ctl_i.op == OP_SET_PRIME)) |-> (val_q >= VALUE_BITS'(2)))
    else $error("value below two reported prime");

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run && (ctl_i.op == OP_EMIT)) |=> (out_valid_q && (is_prime_q == $past(res_q))))
    else $error("result not presented after emit");

endmodule

// File: hdl/trial_division_prime_test.sv
// Trial division prime test: the number of trial divisors tried is up to
// floor(sqrt(value))-1. A new value is taken only once the sequencer is
// back in its idle step, after the last result was emitted; the bit-serial
// remainder unit, one quotient bit per cycle, sets the per-divisor cost.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops
// any pending result; no clearing pass is needed.
module trial_division_prime_test #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  is_prime_o
);
  import tdp_pkg::*;

  // Control word from the microcode ROM and status flags back from the
  // datapath. The program holds in its idle step until a transaction
  // arrives, loads the value, screens out zero and one, then for each
  // divisor d while d*d <= value runs one bit-serial remainder pass and
  // drops out as not prime on a zero remainder. The result lands in an
  // output register, so the next transaction can be taken while it waits.
  dp_ctl_t  ctl;
  dp_stat_t stat;

  tdp_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  tdp_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .is_prime_o  (is_prime_o)
  );

endmodule
